### sv/ddo_pkg.sv
// Shared constants, types and functions of the differential drive odometry block.
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STAGES    = 16;
    localparam int TICK_WIDTH       = 16;
    localparam int CORDIC_TABLE_LEN = 30;

    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int ANG_W       = 32;
    localparam int POS_W       = 32;
    localparam int OUT_W       = 24;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 144;

    localparam int SUM_W       = TICK_WIDTH + 1;
    localparam int SCALE_SHIFT = 9;
    localparam int D_W         = CFG_W + SUM_W - SCALE_SHIFT;
    localparam int DL_W        = 16;
    localparam int DH_W        = D_W - DL_W;
    localparam int STEP_W      = ANG_W + 1;

    localparam int CS_W        = 33;
    localparam int Z_W         = 34;
    localparam int CNT_W       = $clog2(CORDIC_STAGES + 1);
    localparam int ATAN_IDX_W  = $clog2(CORDIC_TABLE_LEN);
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);

    localparam int MUL_A_W     = CFG_W + 1;
    localparam int MUL_B_W     = CS_W;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int ACC_W       = 64;
    localparam int Q30_SHIFT   = 30;

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_METRES_PER_TICK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_DIFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_PER_TICK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_PER_DIFF   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRAV,
        ST_STEP,
        ST_SPD,
        ST_RATE,
        ST_CWAIT,
        ST_XL,
        ST_XH,
        ST_YL,
        ST_YH,
        ST_FIN,
        ST_OUT
    } t_state;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PROD_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = OUT_W'(SAT_HI);
        end else if (v < SAT_LO) begin
            r = OUT_W'(SAT_LO);
        end else begin
            r = OUT_W'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/ddo_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module ddo_mul (
    input  logic                                i_clk,
    input  logic signed [ddo_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [ddo_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [ddo_pkg::PROD_W-1:0]   o_prod
);
    import ddo_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

### sv/ddo_cordic.sv
// Iterative CORDIC rotation giving cosine and sine of a binary angle, one stage per cycle.
`default_nettype none
module ddo_cordic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ddo_pkg::ANG_W-1:0]         i_angle,
    output logic                              o_done,
    output logic signed [ddo_pkg::CS_W-1:0]   o_cos,
    output logic signed [ddo_pkg::CS_W-1:0]   o_sin
);
    import ddo_pkg::*;

    logic signed [CS_W-1:0]  r_x;
    logic signed [CS_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [CNT_W-1:0]        r_i;
    logic                    r_run;
    logic                    r_flip;
    logic                    r_done;
    logic signed [CS_W-1:0]  r_cos;
    logic signed [CS_W-1:0]  r_sin;

    logic                    flip;
    logic signed [ANG_W-1:0] ang_folded;
    logic signed [CS_W-1:0]  xs;
    logic signed [CS_W-1:0]  ys;
    logic signed [Z_W-1:0]   atan_z;

    always_comb begin
        flip       = i_angle[ANG_W-1] ^ i_angle[ANG_W-2];
        ang_folded = signed'(i_angle ^ {flip, {(ANG_W-1){1'b0}}});
        xs         = r_x >>> r_i;
        ys         = r_y >>> r_i;
        atan_z     = signed'(Z_W'(atan_entry(ATAN_IDX_W'(r_i))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= Z_W'(ang_folded);
                r_flip <= flip;
                r_i    <= '0;
                r_run  <= 1'b1;
                r_done <= 1'b0;
            end else if (r_run) begin
                if (r_i == CNT_W'(CORDIC_STAGES)) begin
                    r_cos  <= r_flip ? -r_x : r_x;
                    r_sin  <= r_flip ? -r_y : r_y;
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    if (!r_z[Z_W-1]) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_z;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_z;
                    end
                    r_i    <= r_i + CNT_W'(1);
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule
`default_nettype wire

### sv/differential_drive_odometry.sv
// Differential drive odometry: pose update from wheel encoder ticks, top level.
//
// Input stream: one beat per sample period carries the left and right tick counts.
// Each beat updates the pose (x, y, heading) and yields one output beat with the new
// pose, forward speed and turn rate. Configuration registers are written through
// i_cfg_wr_en / i_cfg_index / i_cfg_wdata by the user only while no beat is in
// flight; the block itself does not enforce this.
//
// Per beat the sequencer runs four passes through the shared multiplier for travel,
// heading step, speed and rate, the CORDIC loop, four more multiplier passes for
// the position deltas, ST_FIN to finish the y delta and ST_OUT to commit the pose.
// s_axis_tready is high only while the sequencer is idle, so a new beat is accepted
// only after the previous one has been committed.
//
// A finished result sits in the output register until taken; the next beat is
// accepted and worked on meanwhile, and the sequencer holds before committing
// its pose while the previous result still waits. Reset clears the pose, the
// configuration registers and the output valid flag.
`default_nettype none
module differential_drive_odometry (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // left_ticks [15:0], right_ticks [31:16]
    input  logic [ddo_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pos_x [31:0], pos_y [63:32], heading_angle [95:64],
    // linear_speed [119:96], turn_rate [143:120]
    output logic [ddo_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_wr_en,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]            i_cfg_wdata
);
    import ddo_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0] r_metres_per_tick;
    logic [CFG_W-1:0] r_angle_per_diff;
    logic [CFG_W-1:0] r_speed_per_tick;
    logic [CFG_W-1:0] r_rate_per_diff;

    logic [POS_W-1:0] r_x;
    logic [POS_W-1:0] r_y;
    logic [ANG_W-1:0] r_heading;
    logic             r_out_valid;
    logic signed [OUT_W-1:0] r_out_speed;
    logic signed [OUT_W-1:0] r_out_rate;

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_diff;
    logic signed [D_W-1:0]    r_d;
    logic [STEP_W-1:0]        r_step;
    logic signed [OUT_W-1:0]  r_speed;
    logic signed [OUT_W-1:0]  r_rate;
    logic signed [ACC_W-1:0]  r_acc;
    logic [POS_W-1:0]         r_dx;
    logic [POS_W-1:0]         r_dy;

    logic signed [TICK_WIDTH-1:0] left_t;
    logic signed [TICK_WIDTH-1:0] right_t;
    logic                         in_beat;
    logic                         commit;
    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic signed [ACC_W-1:0]      acc_sum;
    logic [ANG_W-1:0]             mid_angle;
    logic                         cordic_start;
    logic                         cordic_done;
    logic signed [CS_W-1:0]       cos_v;
    logic signed [CS_W-1:0]       sin_v;

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (mid_angle),
        .o_done  (cordic_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    always_comb begin
        left_t       = signed'(s_axis_tdata[TICK_WIDTH-1:0]);
        right_t      = signed'(s_axis_tdata[16 +: TICK_WIDTH]);
        in_beat      = s_axis_tvalid && s_axis_tready;
        commit       = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);
        acc_sum      = r_acc + (ACC_W'(prod) <<< 16);
        mid_angle    = r_heading + ANG_W'(r_step[STEP_W-1:1]);
        cordic_start = (r_state == ST_RATE);
    end

    always_comb begin
        case (r_state)
            ST_TRAV: begin
                mul_a = signed'(MUL_A_W'(r_metres_per_tick));
                mul_b = MUL_B_W'(r_sum);
            end
            ST_STEP: begin
                mul_a = signed'(MUL_A_W'(r_angle_per_diff));
                mul_b = MUL_B_W'(r_diff);
            end
            ST_SPD: begin
                mul_a = signed'(MUL_A_W'(r_speed_per_tick));
                mul_b = MUL_B_W'(r_sum);
            end
            ST_XL: begin
                mul_a = signed'(MUL_A_W'(r_d[DL_W-1:0]));
                mul_b = cos_v;
            end
            ST_XH: begin
                mul_a = MUL_A_W'(signed'(r_d[D_W-1:DL_W]));
                mul_b = cos_v;
            end
            ST_YL: begin
                mul_a = signed'(MUL_A_W'(r_d[DL_W-1:0]));
                mul_b = sin_v;
            end
            ST_YH: begin
                mul_a = MUL_A_W'(signed'(r_d[D_W-1:DL_W]));
                mul_b = sin_v;
            end
            default: begin
                mul_a = signed'(MUL_A_W'(r_rate_per_diff));
                mul_b = MUL_B_W'(r_diff);
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = ST_TRAV;
            ST_TRAV:  n_state = ST_STEP;
            ST_STEP:  n_state = ST_SPD;
            ST_SPD:   n_state = ST_RATE;
            ST_RATE:  n_state = ST_CWAIT;
            ST_CWAIT: if (cordic_done) n_state = ST_XL;
            ST_XL:    n_state = ST_XH;
            ST_XH:    n_state = ST_YL;
            ST_YL:    n_state = ST_YH;
            ST_YH:    n_state = ST_FIN;
            ST_FIN:   n_state = ST_OUT;
            ST_OUT:   if (commit) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metres_per_tick <= '0;
            r_angle_per_diff  <= '0;
            r_speed_per_tick  <= '0;
            r_rate_per_diff   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_METRES_PER_TICK: r_metres_per_tick <= i_cfg_wdata;
                CFG_ANGLE_PER_DIFF:  r_angle_per_diff  <= i_cfg_wdata;
                CFG_SPEED_PER_TICK:  r_speed_per_tick  <= i_cfg_wdata;
                CFG_RATE_PER_DIFF:   r_rate_per_diff   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_x         <= r_x + r_dx;
                r_y         <= r_y + r_dy;
                r_heading   <= r_heading + r_step[ANG_W-1:0];
                r_out_speed <= r_speed;
                r_out_rate  <= r_rate;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_sum  <= SUM_W'(left_t) + SUM_W'(right_t);
            r_diff <= SUM_W'(right_t) - SUM_W'(left_t);
        end
        case (r_state)
            ST_STEP:  r_d     <= D_W'(prod >>> SCALE_SHIFT);
            ST_SPD:   r_step  <= prod[STEP_W-1:0];
            ST_RATE:  r_speed <= sat_out(prod >>> SCALE_SHIFT);
            ST_CWAIT: r_rate  <= sat_out(prod);
            ST_XH:    r_acc   <= ACC_W'(prod);
            ST_YL:    r_dx    <= acc_sum[Q30_SHIFT +: POS_W];
            ST_YH:    r_acc   <= ACC_W'(prod);
            ST_FIN:   r_dy    <= acc_sum[Q30_SHIFT +: POS_W];
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_rate, r_out_speed, r_heading, r_y, r_x};

endmodule
`default_nettype wire

### tb/sv/tb_differential_drive_odometry.sv
// Self-checking testbench for the differential drive odometry block: predicted pose vs output beats.
module tb_differential_drive_odometry;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BEATS   = 230;
    localparam int DRAIN_CYCLES  = 40;
    localparam longint SAT_MAX   = 64'sd8388607;
    localparam longint SAT_MIN   = -64'sd8388608;

    // arctangent per rotation, binary angle units, entry 0 in the lowest word
    localparam logic [29:0][31:0] ARCTAN_LUT = {
        32'h00000001, 32'h00000002, 32'h00000005, 32'h0000000A, 32'h00000014,
        32'h00000028, 32'h00000051, 32'h000000A2, 32'h00000145, 32'h0000028B,
        32'h00000517, 32'h00000A2F, 32'h0000145F, 32'h000028BE, 32'h0000517C,
        32'h0000A2F9, 32'h000145F3, 32'h00028BE6, 32'h000517CC, 32'h000A2F98,
        32'h00145F2E, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E, 32'h0145D7E1,
        32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051D, 32'h20000000
    };

    typedef struct packed {
        logic signed [TICK_WIDTH-1:0] right_ticks;
        logic signed [TICK_WIDTH-1:0] left_ticks;
    } tick_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] turn_rate;
        logic signed [OUT_W-1:0] linear_speed;
        logic [ANG_W-1:0]        heading_angle;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_x;
    } pose_beat_t;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    // left_ticks [15:0], right_ticks [31:16]
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // pos_x [31:0], pos_y [63:32], heading_angle [95:64],
    // linear_speed [119:96], turn_rate [143:120]
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic                    i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_W-1:0]        i_cfg_wdata   = '0;

    logic [CFG_W-1:0] cfg_metres;
    logic [CFG_W-1:0] cfg_angle;
    logic [CFG_W-1:0] cfg_speed;
    logic [CFG_W-1:0] cfg_rate;
    logic [POS_W-1:0] pose_x;
    logic [POS_W-1:0] pose_y;
    logic [ANG_W-1:0] pose_heading;

    tick_beat_t tick_q[$];
    pose_beat_t pose_expect_q[$];
    pose_beat_t got;
    pose_beat_t want;
    int ticks_queued = 0;
    int ticks_taken  = 0;
    int mismatches   = 0;
    int burst_left   = 0;
    int idle_left    = 0;
    int stall_mode   = 0;
    logic [7:0] stall_tick = '0;

    differential_drive_odometry i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clamp24(input longint v);
        if (v > SAT_MAX) begin
            return SAT_MAX;
        end else if (v < SAT_MIN) begin
            return SAT_MIN;
        end
        return v;
    endfunction

    function automatic pose_beat_t advance_pose(input tick_beat_t t);
        pose_beat_t res;
        longint tick_sum, tick_diff, travel, step, cx, cy, cz, xs, ys;
        logic [ANG_W-1:0] mid;
        logic flip;
        logic signed [95:0] prod;
        int i;
        tick_sum  = longint'(t.left_ticks) + longint'(t.right_ticks);
        tick_diff = longint'(t.right_ticks) - longint'(t.left_ticks);
        travel    = (longint'(cfg_metres) * tick_sum) >>> SCALE_SHIFT;
        step      = tick_diff * longint'(cfg_angle);
        mid       = pose_heading + ANG_W'(step >>> 1);

        // fold the left half-plane onto the right one
        flip = (mid[31:30] == 2'b01) || (mid[31:30] == 2'b10);
        if (flip) begin
            mid = mid - 32'h8000_0000;
        end
        cz = longint'($signed(mid));
        cx = longint'(CORDIC_GAIN);
        cy = 0;
        for (i = 0; i < CORDIC_STAGES && i < 30; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cz >= 0) begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(ARCTAN_LUT[i]);
            end else begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(ARCTAN_LUT[i]);
            end
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end

        prod         = 96'(travel) * 96'(cx);
        pose_x       = pose_x + POS_W'(prod >>> 30);
        prod         = 96'(travel) * 96'(cy);
        pose_y       = pose_y + POS_W'(prod >>> 30);
        pose_heading = pose_heading + ANG_W'(step);

        res.pos_x         = pose_x;
        res.pos_y         = pose_y;
        res.heading_angle = pose_heading;
        res.linear_speed  = OUT_W'(clamp24((longint'(cfg_speed) * tick_sum) >>> SCALE_SHIFT));
        res.turn_rate     = OUT_W'(clamp24(longint'(cfg_rate) * tick_diff));
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    task automatic queue_ticks(input int l, input int r);
        tick_beat_t t;
        t.left_ticks  = TICK_WIDTH'(l);
        t.right_ticks = TICK_WIDTH'(r);
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_taken != ticks_queued || pose_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic load_config(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] a,
                               input logic [CFG_W-1:0] s, input logic [CFG_W-1:0] r);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_METRES_PER_TICK;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_index <= CFG_ANGLE_PER_DIFF;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_index <= CFG_SPEED_PER_TICK;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_index <= CFG_RATE_PER_DIFF;
        i_cfg_wdata <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_metres = m;
        cfg_angle  = a;
        cfg_speed  = s;
        cfg_rate   = r;
    endtask

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(1, 1023));
            default: return CFG_W'($urandom());
        endcase
    endfunction

    task automatic queue_random_ticks();
        int base, l, r;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                base = int'($urandom_range(0, 400)) - 200;
                l = base + int'($urandom_range(0, 20)) - 10;
                r = base + int'($urandom_range(0, 20)) - 10;
            end
            6, 7: begin
                l = int'($urandom());
                r = int'($urandom());
            end
            8: begin
                l = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
                r = ($urandom_range(0, 1) == 1) ? -1 : (($urandom_range(0, 1) == 1) ? 32767 : -32768);
            end
            default: begin
                l = int'($urandom_range(0, 65535)) - 32768;
                r = ($urandom_range(0, 1) == 1) ? l : -l;
            end
        endcase
        queue_ticks(l, r);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pose_expect_q.push_back(advance_pose(tick_beat_t'(s_axis_tdata)));
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    s_axis_tdata  <= tick_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = pose_beat_t'(m_axis_tdata);
                if (pose_expect_q.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time,
                             m_axis_tdata);
                    mismatches++;
                end else begin
                    want = pose_expect_q.pop_front();
                    check_field("pos_x", want.pos_x, got.pos_x);
                    check_field("pos_y", want.pos_y, got.pos_y);
                    check_field("heading_angle", want.heading_angle, got.heading_angle);
                    check_field("linear_speed", 32'(want.linear_speed),
                                32'(got.linear_speed));
                    check_field("turn_rate", 32'(want.turn_rate), 32'(got.turn_rate));
                end
            end
            stall_tick <= stall_tick + 8'd1;
            if (stall_tick == 8'd0) begin
                stall_mode = $urandom_range(0, 2);
            end
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    initial begin
        cfg_metres   = '0;
        cfg_angle    = '0;
        cfg_speed    = '0;
        cfg_rate     = '0;
        pose_x       = '0;
        pose_y       = '0;
        pose_heading = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero scales after reset: pose must stay put
        queue_ticks(0, 0);
        queue_ticks(32767, -32768);
        queue_ticks(-32768, 32767);
        wait_drained();

        // half-turn steps: land the mid heading on the quadrant borders
        load_config(24'h800000, 24'h400000, 24'h100000, 24'h010000);
        queue_ticks(-256, 256);
        queue_ticks(100, 100);
        queue_ticks(-256, 256);
        queue_ticks(0, 0);
        queue_ticks(-1, -1);
        queue_ticks(1, 0);
        wait_drained();

        // full scales: saturate speed and rate both ways, wrap the pose
        load_config('1, '1, '1, '1);
        queue_ticks(32767, 32767);
        queue_ticks(-32768, -32768);
        queue_ticks(32767, -32768);
        queue_ticks(-32768, 32767);
        queue_ticks(-1, 0);
        queue_ticks(0, -1);
        queue_ticks(12345, -23456);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            load_config(pick_setting(), pick_setting(), pick_setting(), pick_setting());
            repeat (PHASE_BEATS) queue_random_ticks();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_differential_drive_odometry: PASS");
        end else begin
            $display("tb_differential_drive_odometry: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_differential_drive_odometry: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/ddo_pkg.sv
sv/ddo_mul.sv
sv/ddo_cordic.sv
sv/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
